// ----- src/l1vc_pkg.sv -----
// shared types, constants and codes for the three-level cache tag block
package l1vc_pkg;

    localparam int L1_SETS_DEF = 16;
    localparam int L2_WAYS_DEF = 8;
    localparam int VC_DEPTH_DEF = 4;
    localparam int L2_SETS_DEF = 16;

    localparam int ADDR_W = 32;
    localparam int WORD_W = 32;
    localparam int BLOCK_W = ADDR_W - 2;

    typedef struct packed {
        logic               mode;
        logic [ADDR_W-1:0]  word_address;
        logic signed [WORD_W-1:0] write_word;
    } access_t;

    typedef struct packed {
        logic [1:0]         hit_level;
        logic               memory_write;
        logic signed [WORD_W-1:0] memory_word;
    } result_t;

    typedef enum logic [1:0] {
        LVL_L1  = 2'd0,
        LVL_VC  = 2'd1,
        LVL_L2  = 2'd2,
        LVL_MEM = 2'd3
    } level_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RD2,
        ST_INS,
        ST_FIN
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic rd2;
        logic ins;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic cascade;
        logic out_free;
    } dp_sts_t;

endpackage

// ----- src/l1vc_ctrl.sv -----
// sequencer for lookup, update and second-level insert of one transaction
module l1vc_ctrl
    import l1vc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    access_valid,
    output logic    access_stall,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (access_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = sts.cascade ? ST_RD2 : ST_FIN;
            end
            ST_RD2:
            begin
                state_next = ST_INS;
            end
            ST_INS:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        access_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                access_stall = 1'b0;
                cmd.capture = access_valid;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            ST_RD2:
            begin
                cmd.rd2 = 1'b1;
            end
            ST_INS:
            begin
                cmd.ins = 1'b1;
            end
            ST_FIN:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- src/l1vc_datapath.sv -----
// tag stores, lru ages, second-level set memory and result register
module l1vc_datapath
    import l1vc_pkg::*;
#(
    parameter int FIRST_LEVEL_SETS  = L1_SETS_DEF,
    parameter int SECOND_LEVEL_WAYS = L2_WAYS_DEF,
    parameter int VICTIM_DEPTH      = VC_DEPTH_DEF,
    parameter int SECOND_LEVEL_SETS = L2_SETS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  dp_cmd_t cmd,
    output dp_sts_t sts,
    input  access_t access,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int L1_IW = $clog2(FIRST_LEVEL_SETS);
    localparam int L2_IW = $clog2(SECOND_LEVEL_SETS);
    localparam int VA_W  = $clog2(VICTIM_DEPTH);
    localparam int VS_W  = $clog2(VICTIM_DEPTH);
    localparam int LA_W  = $clog2(SECOND_LEVEL_WAYS);
    localparam int WS_W  = $clog2(SECOND_LEVEL_WAYS);
    localparam int ENT_W = BLOCK_W + LA_W;
    localparam logic [VA_W-1:0] VC_MRU = VA_W'(VICTIM_DEPTH - 1);
    localparam logic [LA_W-1:0] L2_MRU = LA_W'(SECOND_LEVEL_WAYS - 1);

    typedef logic [SECOND_LEVEL_WAYS-1:0][ENT_W-1:0] row_t;

    access_t acc_reg;
    logic [BLOCK_W-1:0] blk;
    logic [L1_IW-1:0] idx;
    logic [L2_IW-1:0] set_a;

    logic l1_valid_reg [FIRST_LEVEL_SETS];
    logic [BLOCK_W-1:0] l1_block_reg [FIRST_LEVEL_SETS];

    logic vc_valid_reg [VICTIM_DEPTH];
    logic [BLOCK_W-1:0] vc_block_reg [VICTIM_DEPTH];
    logic [VA_W-1:0] vc_age_reg [VICTIM_DEPTH];
    logic vc_valid_next [VICTIM_DEPTH];
    logic [BLOCK_W-1:0] vc_block_next [VICTIM_DEPTH];
    logic [VA_W-1:0] vc_age_next [VICTIM_DEPTH];

    logic [SECOND_LEVEL_WAYS-1:0] l2_valid_reg [SECOND_LEVEL_SETS];
    row_t l2_mem [SECOND_LEVEL_SETS];
    row_t row_q;
    logic [L2_IW-1:0] rd_addr;
    logic [L2_IW-1:0] wr_addr;
    row_t wr_data;
    logic mem_we;

    logic [BLOCK_W-1:0] casc_blk_reg;
    logic [BLOCK_W-1:0] casc_blk;
    logic [L2_IW-1:0] casc_set;
    logic cascade;

    logic l1_hit;
    logic l1_we;
    logic l2_we_e;
    row_t row_eval;
    logic [SECOND_LEVEL_WAYS-1:0] valid_eval;
    row_t row_ins;
    logic [SECOND_LEVEL_WAYS-1:0] valid_ins;
    level_t level;

    result_t res_reg;
    result_t result_reg;
    logic result_valid_reg;

    assign blk = acc_reg.word_address[ADDR_W-1:2];
    assign idx = blk[L1_IW-1:0];
    assign set_a = blk[L2_IW-1:0];
    assign casc_set = casc_blk_reg[L2_IW-1:0];
    assign l1_hit = l1_valid_reg[idx] && (l1_block_reg[idx] == blk);

    always_comb
    begin : eval_comb
        logic vhit;
        logic [VS_W-1:0] vp;
        logic [VA_W-1:0] vpa;
        logic vfound;
        logic [VS_W-1:0] vslot;
        logic whit;
        logic [WS_W-1:0] wp;
        logic [LA_W-1:0] wpa;
        logic [BLOCK_W-1:0] eb [SECOND_LEVEL_WAYS];
        logic [LA_W-1:0] ea [SECOND_LEVEL_WAYS];
        logic fill;

        for (int i = 0; i < VICTIM_DEPTH; i++)
        begin
            vc_valid_next[i] = vc_valid_reg[i];
            vc_block_next[i] = vc_block_reg[i];
            vc_age_next[i] = vc_age_reg[i];
        end
        for (int w = 0; w < SECOND_LEVEL_WAYS; w++)
        begin
            eb[w] = row_q[w][ENT_W-1:LA_W];
            ea[w] = row_q[w][LA_W-1:0];
        end
        valid_eval = l2_valid_reg[set_a];
        l1_we = 1'b0;
        l2_we_e = 1'b0;
        cascade = 1'b0;
        casc_blk = vc_block_reg[0];
        fill = 1'b0;
        vfound = 1'b0;
        vslot = '0;

        vhit = 1'b0;
        vp = '0;
        for (int i = 0; i < VICTIM_DEPTH; i++)
        begin
            if (!vhit && vc_valid_reg[i] && (vc_block_reg[i] == blk))
            begin
                vhit = 1'b1;
                vp = VS_W'(i);
            end
        end
        vpa = vc_age_reg[vp];

        whit = 1'b0;
        wp = '0;
        for (int w = 0; w < SECOND_LEVEL_WAYS; w++)
        begin
            if (!whit && valid_eval[w] && (eb[w] == blk))
            begin
                whit = 1'b1;
                wp = WS_W'(w);
            end
        end
        wpa = ea[wp];

        priority if (l1_hit)
        begin
            level = LVL_L1;
        end
        else if (vhit)
        begin
            level = LVL_VC;
            if (acc_reg.mode || l1_valid_reg[idx])
            begin
                // touch
                for (int i = 0; i < VICTIM_DEPTH; i++)
                begin
                    if (vc_valid_reg[i] && (VS_W'(i) != vp) && (vc_age_reg[i] > vpa))
                    begin
                        vc_age_next[i] = vc_age_reg[i] - 1'b1;
                    end
                end
                vc_age_next[vp] = VC_MRU;
                if (!acc_reg.mode)
                begin
                    vc_block_next[vp] = l1_block_reg[idx];
                    l1_we = 1'b1;
                end
            end
            else
            begin
                // remove
                vc_valid_next[vp] = 1'b0;
                for (int i = 0; i < VICTIM_DEPTH; i++)
                begin
                    if (vc_valid_reg[i] && (VS_W'(i) != vp) && (vc_age_reg[i] < vpa))
                    begin
                        vc_age_next[i] = vc_age_reg[i] + 1'b1;
                    end
                end
                l1_we = 1'b1;
            end
        end
        else if (whit)
        begin
            level = LVL_L2;
            l2_we_e = 1'b1;
            if (acc_reg.mode)
            begin
                for (int w = 0; w < SECOND_LEVEL_WAYS; w++)
                begin
                    if (valid_eval[w] && (WS_W'(w) != wp) && (ea[w] > wpa))
                    begin
                        ea[w] = ea[w] - 1'b1;
                    end
                end
                ea[wp] = L2_MRU;
            end
            else
            begin
                valid_eval[wp] = 1'b0;
                for (int w = 0; w < SECOND_LEVEL_WAYS; w++)
                begin
                    if (valid_eval[w] && (ea[w] < wpa))
                    begin
                        ea[w] = ea[w] + 1'b1;
                    end
                end
                fill = 1'b1;
            end
        end
        else
        begin
            level = LVL_MEM;
            fill = !acc_reg.mode;
        end

        if (fill)
        begin
            l1_we = 1'b1;
            if (l1_valid_reg[idx])
            begin
                // displaced line into the victim cache
                for (int i = 0; i < VICTIM_DEPTH; i++)
                begin
                    if (!vc_valid_reg[i])
                    begin
                        vslot = VS_W'(i);
                        vfound = 1'b1;
                    end
                end
                if (!vfound)
                begin
                    vslot = '0;
                    for (int i = 1; i < VICTIM_DEPTH; i++)
                    begin
                        if (vc_age_reg[i] < vc_age_reg[vslot])
                        begin
                            vslot = VS_W'(i);
                        end
                    end
                    cascade = 1'b1;
                    casc_blk = vc_block_reg[vslot];
                    vc_valid_next[vslot] = 1'b0;
                end
                for (int i = 0; i < VICTIM_DEPTH; i++)
                begin
                    if (vc_valid_next[i] && (vc_age_reg[i] != '0))
                    begin
                        vc_age_next[i] = vc_age_reg[i] - 1'b1;
                    end
                end
                vc_valid_next[vslot] = 1'b1;
                vc_block_next[vslot] = l1_block_reg[idx];
                vc_age_next[vslot] = VC_MRU;
            end
        end

        for (int w = 0; w < SECOND_LEVEL_WAYS; w++)
        begin
            row_eval[w] = {eb[w], ea[w]};
        end
    end

    always_comb
    begin : ins_comb
        logic [BLOCK_W-1:0] ib [SECOND_LEVEL_WAYS];
        logic [LA_W-1:0] ia [SECOND_LEVEL_WAYS];
        logic ifound;
        logic [WS_W-1:0] islot;

        valid_ins = l2_valid_reg[casc_set];
        for (int w = 0; w < SECOND_LEVEL_WAYS; w++)
        begin
            ib[w] = row_q[w][ENT_W-1:LA_W];
            ia[w] = row_q[w][LA_W-1:0];
        end
        ifound = 1'b0;
        islot = '0;
        for (int w = 0; w < SECOND_LEVEL_WAYS; w++)
        begin
            if (!valid_ins[w])
            begin
                islot = WS_W'(w);
                ifound = 1'b1;
            end
        end
        if (!ifound)
        begin
            islot = '0;
            for (int w = 1; w < SECOND_LEVEL_WAYS; w++)
            begin
                if (ia[w] < ia[islot])
                begin
                    islot = WS_W'(w);
                end
            end
            valid_ins[islot] = 1'b0;
        end
        for (int w = 0; w < SECOND_LEVEL_WAYS; w++)
        begin
            if (valid_ins[w] && (ia[w] != '0))
            begin
                ia[w] = ia[w] - 1'b1;
            end
        end
        valid_ins[islot] = 1'b1;
        ib[islot] = casc_blk_reg;
        ia[islot] = L2_MRU;
        for (int w = 0; w < SECOND_LEVEL_WAYS; w++)
        begin
            row_ins[w] = {ib[w], ia[w]};
        end
    end

    // set memory
    assign rd_addr = cmd.capture ? access.word_address[L2_IW+1:2] : casc_set;
    assign mem_we = (cmd.eval && l2_we_e) || cmd.ins;
    assign wr_addr = cmd.ins ? casc_set : set_a;
    assign wr_data = cmd.ins ? row_ins : row_eval;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            l2_mem[wr_addr] <= wr_data;
        end
        row_q <= l2_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SECOND_LEVEL_SETS; s++)
            begin
                l2_valid_reg[s] <= '0;
            end
            for (int i = 0; i < FIRST_LEVEL_SETS; i++)
            begin
                l1_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < VICTIM_DEPTH; i++)
            begin
                vc_valid_reg[i] <= 1'b0;
                vc_age_reg[i] <= '0;
            end
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.eval && l2_we_e)
            begin
                l2_valid_reg[set_a] <= valid_eval;
            end
            if (cmd.ins)
            begin
                l2_valid_reg[casc_set] <= valid_ins;
            end
            if (cmd.eval)
            begin
                if (l1_we)
                begin
                    l1_valid_reg[idx] <= 1'b1;
                end
                for (int i = 0; i < VICTIM_DEPTH; i++)
                begin
                    vc_valid_reg[i] <= vc_valid_next[i];
                    vc_age_reg[i] <= vc_age_next[i];
                end
            end
            if (cmd.load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            acc_reg <= access;
        end
        if (cmd.eval)
        begin
            if (l1_we)
            begin
                l1_block_reg[idx] <= blk;
            end
            for (int i = 0; i < VICTIM_DEPTH; i++)
            begin
                vc_block_reg[i] <= vc_block_next[i];
            end
            casc_blk_reg <= casc_blk;
            res_reg.hit_level <= level;
            res_reg.memory_write <= acc_reg.mode;
            res_reg.memory_word <= acc_reg.mode ? acc_reg.write_word : '0;
        end
        if (cmd.load_out)
        begin
            result_reg <= res_reg;
        end
    end

    assign sts.cascade = cascade;
    assign sts.out_free = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    a_ins_after_rd2: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |-> $past(cmd.rd2))
        else $error("second-level insert without set read");

    a_rd2_after_cascade: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd2 |-> ($past(cmd.eval) && $past(sts.cascade)))
        else $error("set read without victim eviction");

    a_l1_hit_no_cascade: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.eval && l1_hit) |-> (!cascade && !l1_we && !l2_we_e))
        else $error("first-level hit changed placement");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result_valid_reg || !result_stall))
        else $error("result overwritten before taken");

endmodule

// ----- src/l1_victim_l2_cache_tags.sv -----
// top level of the three-level cache tag block
//
//  channel   signals                                   dir
//  access    access_valid, access_stall, access        in
//  result    result_valid, result_stall, result        out
//
// one transaction passes through capture and set read, lookup and update, and result load
// a read that evicts a victim entry adds a second-level set read and insert
// the set memory's registered read means the evicted entry's set needs a read of its own
// reset invalidates every line, victim entry and second-level way at once
// a stalled result holds in the output register while the next transaction is taken
module l1_victim_l2_cache_tags
    import l1vc_pkg::*;
#(
    parameter int FIRST_LEVEL_SETS  = L1_SETS_DEF,
    parameter int SECOND_LEVEL_WAYS = L2_WAYS_DEF,
    parameter int VICTIM_DEPTH      = VC_DEPTH_DEF,
    parameter int SECOND_LEVEL_SETS = L2_SETS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    access_valid,
    output logic    access_stall,
    input  access_t access,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    l1vc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .access_valid (access_valid),
        .access_stall (access_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    l1vc_datapath #(
        .FIRST_LEVEL_SETS  (FIRST_LEVEL_SETS),
        .SECOND_LEVEL_WAYS (SECOND_LEVEL_WAYS),
        .VICTIM_DEPTH      (VICTIM_DEPTH),
        .SECOND_LEVEL_SETS (SECOND_LEVEL_SETS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .access       (access),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ----- tb/tb.sv -----
// testbench for the three-level cache tag block: predicts hit level and write-through per access
`timescale 1ns / 1ps
module tb;
    import l1vc_pkg::*;

    localparam int L1N = L1_SETS_DEF;
    localparam int VCN = VC_DEPTH_DEF;
    localparam int L2W = L2_WAYS_DEF;
    localparam int L2N = L2_SETS_DEF;
    localparam int WATCH_LIMIT = 20000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    access_valid = 1'b0;
    logic    access_stall;
    access_t access = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    l1_victim_l2_cache_tags dut (
        .clk(clk), .rst_n(rst_n),
        .access_valid(access_valid), .access_stall(access_stall), .access(access),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    bit                l1_v [L1N];
    bit [BLOCK_W-1:0]  l1_b [L1N];
    bit                vc_v [VCN];
    bit [BLOCK_W-1:0]  vc_b [VCN];
    int                vc_a [VCN];
    bit                l2_v [L2N][L2W];
    bit [BLOCK_W-1:0]  l2_b [L2N][L2W];
    int                l2_a [L2N][L2W];

    access_t pending_accesses [$];
    result_t expected_results [$];
    bit      pause_for_drain = 1'b0;
    bit      quiet_mode = 1'b0;
    int      fail_count = 0;
    int      checked = 0;
    int      idle_cycles = 0;
    int      level_seen [4];

    function automatic void l2_insert(bit [BLOCK_W-1:0] blk);
        int s, slot;
        s = blk % L2N;
        slot = -1;
        for (int i = 0; i < L2W; i++)
            if (!l2_v[s][i]) slot = i;
        if (slot < 0)
        begin
            slot = 0;
            for (int i = 1; i < L2W; i++)
                if (l2_a[s][i] < l2_a[s][slot]) slot = i;
            l2_v[s][slot] = 1'b0;
        end
        for (int i = 0; i < L2W; i++)
            if (l2_v[s][i] && l2_a[s][i] > 0) l2_a[s][i]--;
        l2_v[s][slot] = 1'b1;
        l2_b[s][slot] = blk;
        l2_a[s][slot] = L2W - 1;
    endfunction

    function automatic void fill_l1(bit [BLOCK_W-1:0] blk);
        int idx, slot;
        idx = blk % L1N;
        if (l1_v[idx])
        begin
            slot = -1;
            for (int i = 0; i < VCN; i++)
                if (!vc_v[i]) slot = i;
            if (slot < 0)
            begin
                slot = 0;
                for (int i = 1; i < VCN; i++)
                    if (vc_a[i] < vc_a[slot]) slot = i;
                vc_v[slot] = 1'b0;
                l2_insert(vc_b[slot]);
            end
            for (int i = 0; i < VCN; i++)
                if (vc_v[i] && vc_a[i] > 0) vc_a[i]--;
            vc_v[slot] = 1'b1;
            vc_b[slot] = l1_b[idx];
            vc_a[slot] = VCN - 1;
        end
        l1_v[idx] = 1'b1;
        l1_b[idx] = blk;
    endfunction

    function automatic result_t predict_access(access_t a);
        result_t r;
        bit [BLOCK_W-1:0] blk;
        int idx, s, vp, wp, old;
        bit wr;
        wr = a.mode;
        blk = a.word_address[ADDR_W-1:2];
        idx = blk % L1N;
        s = blk % L2N;
        vp = -1;
        wp = -1;
        for (int i = VCN - 1; i >= 0; i--)
            if (vc_v[i] && vc_b[i] == blk) vp = i;
        for (int i = L2W - 1; i >= 0; i--)
            if (l2_v[s][i] && l2_b[s][i] == blk) wp = i;
        if (l1_v[idx] && l1_b[idx] == blk)
            r.hit_level = LVL_L1;
        else if (vp >= 0)
        begin
            r.hit_level = LVL_VC;
            if (wr || l1_v[idx])
            begin
                if (!wr)
                begin
                    vc_b[vp] = l1_b[idx];
                    l1_b[idx] = blk;
                end
                for (int i = 0; i < VCN; i++)
                    if (vc_v[i] && i != vp && vc_a[i] > vc_a[vp]) vc_a[i]--;
                vc_a[vp] = VCN - 1;
            end
            else
            begin
                old = vc_a[vp];
                vc_v[vp] = 1'b0;
                for (int i = 0; i < VCN; i++)
                    if (vc_v[i] && vc_a[i] < old) vc_a[i]++;
                l1_v[idx] = 1'b1;
                l1_b[idx] = blk;
            end
        end
        else if (wp >= 0)
        begin
            r.hit_level = LVL_L2;
            if (wr)
            begin
                for (int i = 0; i < L2W; i++)
                    if (l2_v[s][i] && i != wp && l2_a[s][i] > l2_a[s][wp]) l2_a[s][i]--;
                l2_a[s][wp] = L2W - 1;
            end
            else
            begin
                old = l2_a[s][wp];
                l2_v[s][wp] = 1'b0;
                for (int i = 0; i < L2W; i++)
                    if (l2_v[s][i] && l2_a[s][i] < old) l2_a[s][i]++;
                fill_l1(blk);
            end
        end
        else
        begin
            r.hit_level = LVL_MEM;
            if (!wr) fill_l1(blk);
        end
        r.memory_write = wr;
        r.memory_word = wr ? a.write_word : '0;
        return r;
    endfunction

    function automatic access_t make_access(bit wr, bit [31:0] addr, bit [31:0] word);
        access_t a;
        a.mode = wr;
        a.word_address = addr;
        a.write_word = word;
        return a;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!access_valid || !access_stall)
            begin
                if (pending_accesses.size() > 0 && !pause_for_drain
                    && (quiet_mode || $urandom_range(99) >= 18))
                begin
                    access_t a;
                    a = pending_accesses.pop_front();
                    expected_results.push_back(predict_access(a));
                    access <= a;
                    access_valid <= 1'b1;
                end
                else
                    access_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((access_valid && !access_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, result);
                    fail_count++;
                end
                else
                begin
                    result_t e;
                    e = expected_results.pop_front();
                    checked++;
                    level_seen[e.hit_level]++;
                    if (e.hit_level !== result.hit_level
                        || e.memory_write !== result.memory_write
                        || e.memory_word !== result.memory_word)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, result);
                        fail_count++;
                    end
                end
            end
            result_stall <= !quiet_mode && ($urandom_range(99) < 18);
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        bit [31:0] addr;
        // directed: field extremes, both modes, l2 hits, cascade
        pending_accesses.push_back(make_access(1'b0, 32'h0, 32'h0));
        pending_accesses.push_back(make_access(1'b1, 32'h0, 32'h7fffffff));
        pending_accesses.push_back(make_access(1'b1, 32'hffffffff, 32'h80000000));
        pending_accesses.push_back(make_access(1'b0, 32'hffffffff, 32'hffffffff));
        for (int t = 1; t <= 6; t++)
            pending_accesses.push_back(make_access(1'b0, t << 6, $urandom));
        pending_accesses.push_back(make_access(1'b1, 32'h40, 32'h12345678));
        pending_accesses.push_back(make_access(1'b0, 32'h40, 32'h0));
        pending_accesses.push_back(make_access(1'b1, 32'h0, 32'h1));
        pending_accesses.push_back(make_access(1'b0, 32'h0, 32'h0));
        pending_accesses.push_back(make_access(1'b0, 32'h4, 32'h0));
        pending_accesses.push_back(make_access(1'b0, 32'h5, 32'h0));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_accesses.size() == 0);
        pause_for_drain = 1'b1;
        wait (expected_results.size() == 0 && !access_valid);
        repeat (10) @(posedge clk);
        pause_for_drain = 1'b0;
        // random: a few sets with few tags so lines cycle through all levels
        for (int n = 0; n < 1950; n++)
        begin
            if ($urandom_range(9) == 0)
                addr = $urandom;
            else
                addr = (32'($urandom_range(3)) << 10) | (32'($urandom_range(11)) << 6)
                       | (32'($urandom_range(3)) << 2) | 32'($urandom_range(3))
                       | (($urandom_range(7) == 0) ? 32'hfff00000 : 32'h0);
            pending_accesses.push_back(make_access($urandom_range(3) == 0, addr, $urandom));
            if (n == 600)
            begin
                wait (pending_accesses.size() == 0);
                quiet_mode = 1'b1;
            end
            if (n == 900)
            begin
                wait (pending_accesses.size() == 0);
                quiet_mode = 1'b0;
            end
        end
        wait (pending_accesses.size() == 0);
        wait (expected_results.size() == 0);
        repeat (20) @(posedge clk);
        $display("tb: %0d accesses checked; l1 %0d, victim %0d, l2 %0d, memory %0d hits",
                 checked, level_seen[0], level_seen[1], level_seen[2], level_seen[3]);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
